@@ hdl/psimd_pkg.sv @@
// -----------------------------------------------------------------------------
// psimd_pkg
// Shared codes and widths for the packed-integer SIMD ALU.
// -----------------------------------------------------------------------------
package psimd_pkg;

  localparam int CMD_W    = 6;
  localparam int DATA_W   = 64;
  localparam int COUNT_W  = 32;
  // command + operand_a + operand_b + shift_count, padded to whole bytes
  localparam int IN_BITS  = CMD_W + 2 * DATA_W + COUNT_W;
  localparam int S_DATA_W = ((IN_BITS + 7) / 8) * 8;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_ADD_B     = 6'd0;
  localparam cmd_t CMD_ADD_W     = 6'd1;
  localparam cmd_t CMD_ADD_D     = 6'd2;
  localparam cmd_t CMD_ADDS_B    = 6'd3;
  localparam cmd_t CMD_ADDS_W    = 6'd4;
  localparam cmd_t CMD_ADDUS_B   = 6'd5;
  localparam cmd_t CMD_ADDUS_W   = 6'd6;
  localparam cmd_t CMD_SUB_B     = 6'd7;
  localparam cmd_t CMD_SUB_W     = 6'd8;
  localparam cmd_t CMD_SUB_D     = 6'd9;
  localparam cmd_t CMD_SUBS_B    = 6'd10;
  localparam cmd_t CMD_SUBS_W    = 6'd11;
  localparam cmd_t CMD_SUBUS_B   = 6'd12;
  localparam cmd_t CMD_SUBUS_W   = 6'd13;
  localparam cmd_t CMD_CMPEQ_B   = 6'd14;
  localparam cmd_t CMD_CMPEQ_W   = 6'd15;
  localparam cmd_t CMD_CMPEQ_D   = 6'd16;
  localparam cmd_t CMD_CMPGT_B   = 6'd17;
  localparam cmd_t CMD_CMPGT_W   = 6'd18;
  localparam cmd_t CMD_CMPGT_D   = 6'd19;
  localparam cmd_t CMD_MULL_W    = 6'd20;
  localparam cmd_t CMD_MULH_W    = 6'd21;
  localparam cmd_t CMD_MADD_WD   = 6'd22;
  localparam cmd_t CMD_UNPCKL_BW = 6'd23;
  localparam cmd_t CMD_UNPCKL_WD = 6'd24;
  localparam cmd_t CMD_UNPCKL_DQ = 6'd25;
  localparam cmd_t CMD_UNPCKH_BW = 6'd26;
  localparam cmd_t CMD_UNPCKH_WD = 6'd27;
  localparam cmd_t CMD_UNPCKH_DQ = 6'd28;
  localparam cmd_t CMD_PACKSS_WB = 6'd29;
  localparam cmd_t CMD_PACKSS_DW = 6'd30;
  localparam cmd_t CMD_PACKUS_WB = 6'd31;
  localparam cmd_t CMD_SLL_W     = 6'd32;
  localparam cmd_t CMD_SLL_D     = 6'd33;
  localparam cmd_t CMD_SLL_Q     = 6'd34;
  localparam cmd_t CMD_SRL_W     = 6'd35;
  localparam cmd_t CMD_SRL_D     = 6'd36;
  localparam cmd_t CMD_SRL_Q     = 6'd37;
  localparam cmd_t CMD_SRA_W     = 6'd38;
  localparam cmd_t CMD_SRA_D     = 6'd39;
  localparam cmd_t CMD_SRA_Q     = 6'd40;

  // per-lane arithmetic/compare operation
  typedef logic [2:0] lop_t;

  localparam lop_t LOP_ADD   = 3'd0;
  localparam lop_t LOP_SUB   = 3'd1;
  localparam lop_t LOP_ADDS  = 3'd2;
  localparam lop_t LOP_SUBS  = 3'd3;
  localparam lop_t LOP_ADDUS = 3'd4;
  localparam lop_t LOP_SUBUS = 3'd5;
  localparam lop_t LOP_CMPEQ = 3'd6;
  localparam lop_t LOP_CMPGT = 3'd7;

endpackage

@@ hdl/psimd_lane.sv @@
// -----------------------------------------------------------------------------
// psimd_lane
// One add/sub/saturate/compare lane of width W.
// -----------------------------------------------------------------------------
module psimd_lane #(
  parameter int W = 8
) (
  input  psimd_pkg::lop_t lop,
  input  logic [W-1:0]    a,
  input  logic [W-1:0]    b,
  output logic [W-1:0]    r
);

  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic [W:0] usum;
  logic [W:0] udiff;
  logic [W:0] ssum;
  logic [W:0] sdiff;

  assign usum  = {1'b0, a} + {1'b0, b};
  assign udiff = {1'b0, a} - {1'b0, b};
  assign ssum  = {a[W-1], a} + {b[W-1], b};
  assign sdiff = {a[W-1], a} - {b[W-1], b};

  always_comb begin
    case (lop)
      psimd_pkg::LOP_ADD:   r = usum[W-1:0];
      psimd_pkg::LOP_SUB:   r = udiff[W-1:0];
      // overflow when the two top bits of the extended sum disagree
      psimd_pkg::LOP_ADDS:  r = (ssum[W] != ssum[W-1]) ? (ssum[W] ? SMIN : SMAX)
                                                       : ssum[W-1:0];
      psimd_pkg::LOP_SUBS:  r = (sdiff[W] != sdiff[W-1]) ? (sdiff[W] ? SMIN : SMAX)
                                                         : sdiff[W-1:0];
      psimd_pkg::LOP_ADDUS: r = usum[W] ? {W{1'b1}} : usum[W-1:0];
      psimd_pkg::LOP_SUBUS: r = udiff[W] ? '0 : udiff[W-1:0];
      psimd_pkg::LOP_CMPEQ: r = (a == b) ? {W{1'b1}} : '0;
      psimd_pkg::LOP_CMPGT: r = ($signed(a) > $signed(b)) ? {W{1'b1}} : '0;
      default:              r = '0;
    endcase
  end

endmodule

@@ hdl/psimd_exec.sv @@
// -----------------------------------------------------------------------------
// psimd_exec
// Combinational datapath: lane ALUs, multiplies, unpack, pack, shifts, select.
// -----------------------------------------------------------------------------
module psimd_exec (
  input  psimd_pkg::cmd_t                     command,
  input  logic [psimd_pkg::DATA_W-1:0]        operand_a,
  input  logic [psimd_pkg::DATA_W-1:0]        operand_b,
  input  logic [psimd_pkg::COUNT_W-1:0]       shift_count,
  output logic [psimd_pkg::DATA_W-1:0]        result
);

  function automatic logic [7:0] sat_s16_s8(input logic [15:0] v);
    if (!v[15] && (v[15:7] != 9'h000))      return 8'h7f;
    else if (v[15] && (v[15:7] != 9'h1ff))  return 8'h80;
    else                                    return v[7:0];
  endfunction

  function automatic logic [7:0] sat_s16_u8(input logic [15:0] v);
    if (v[15])                  return 8'h00;
    else if (v[15:8] != 8'h00)  return 8'hff;
    else                        return v[7:0];
  endfunction

  function automatic logic [15:0] sat_s32_s16(input logic [31:0] v);
    if (!v[31] && (v[31:15] != 17'h00000))      return 16'h7fff;
    else if (v[31] && (v[31:15] != 17'h1ffff))  return 16'h8000;
    else                                        return v[15:0];
  endfunction

  psimd_pkg::lop_t lop;

  logic [63:0] r8, r16, r32;
  logic signed [31:0] prod [4];
  logic [63:0] mull, mulh, madd;
  logic [63:0] unl_bw, unl_wd, unl_dq, unh_bw, unh_wd, unh_dq;
  logic [63:0] pk_sswb, pk_ssdw, pk_uswb;
  logic [63:0] sll16, srl16, sra16, sll32, srl32, sra32, sll64, srl64, sra64;
  logic        ok16, ok32, ok64;
  logic [3:0]  na16;
  logic [4:0]  na32;
  logic [5:0]  na64;

  // lane operation for the lanewise commands
  always_comb begin
    unique case (command) inside
      psimd_pkg::CMD_ADD_B, psimd_pkg::CMD_ADD_W, psimd_pkg::CMD_ADD_D:
        lop = psimd_pkg::LOP_ADD;
      psimd_pkg::CMD_ADDS_B, psimd_pkg::CMD_ADDS_W:
        lop = psimd_pkg::LOP_ADDS;
      psimd_pkg::CMD_ADDUS_B, psimd_pkg::CMD_ADDUS_W:
        lop = psimd_pkg::LOP_ADDUS;
      psimd_pkg::CMD_SUB_B, psimd_pkg::CMD_SUB_W, psimd_pkg::CMD_SUB_D:
        lop = psimd_pkg::LOP_SUB;
      psimd_pkg::CMD_SUBS_B, psimd_pkg::CMD_SUBS_W:
        lop = psimd_pkg::LOP_SUBS;
      psimd_pkg::CMD_SUBUS_B, psimd_pkg::CMD_SUBUS_W:
        lop = psimd_pkg::LOP_SUBUS;
      psimd_pkg::CMD_CMPEQ_B, psimd_pkg::CMD_CMPEQ_W, psimd_pkg::CMD_CMPEQ_D:
        lop = psimd_pkg::LOP_CMPEQ;
      psimd_pkg::CMD_CMPGT_B, psimd_pkg::CMD_CMPGT_W, psimd_pkg::CMD_CMPGT_D:
        lop = psimd_pkg::LOP_CMPGT;
      default:
        lop = psimd_pkg::LOP_ADD;
    endcase
  end

  for (genvar g = 0; g < 8; g++) begin : g_b
    psimd_lane #(.W(8)) u_lane (
      .lop (lop),
      .a   (operand_a[8*g +: 8]),
      .b   (operand_b[8*g +: 8]),
      .r   (r8[8*g +: 8])
    );
  end

  for (genvar g = 0; g < 4; g++) begin : g_w
    psimd_lane #(.W(16)) u_lane (
      .lop (lop),
      .a   (operand_a[16*g +: 16]),
      .b   (operand_b[16*g +: 16]),
      .r   (r16[16*g +: 16])
    );
  end

  for (genvar g = 0; g < 2; g++) begin : g_d
    psimd_lane #(.W(32)) u_lane (
      .lop (lop),
      .a   (operand_a[32*g +: 32]),
      .b   (operand_b[32*g +: 32]),
      .r   (r32[32*g +: 32])
    );
  end

  // signed 16x16 word products, shared by mull/mulh/madd
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = $signed(operand_a[16*i +: 16]) * $signed(operand_b[16*i +: 16]);
      mull[16*i +: 16] = prod[i][15:0];
      mulh[16*i +: 16] = prod[i][31:16];
    end
    // low 32 bits of each pair sum, wraps on the -32768 squared case
    madd[31:0]  = prod[0] + prod[1];
    madd[63:32] = prod[2] + prod[3];
  end

  // interleaves: operand_a on even lanes, operand_b on odd lanes
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      unl_bw[16*i +: 8]     = operand_a[8*i +: 8];
      unl_bw[16*i + 8 +: 8] = operand_b[8*i +: 8];
      unh_bw[16*i +: 8]     = operand_a[32 + 8*i +: 8];
      unh_bw[16*i + 8 +: 8] = operand_b[32 + 8*i +: 8];
    end
    for (int i = 0; i < 2; i++) begin
      unl_wd[32*i +: 16]      = operand_a[16*i +: 16];
      unl_wd[32*i + 16 +: 16] = operand_b[16*i +: 16];
      unh_wd[32*i +: 16]      = operand_a[32 + 16*i +: 16];
      unh_wd[32*i + 16 +: 16] = operand_b[32 + 16*i +: 16];
    end
    unl_dq = {operand_b[31:0], operand_a[31:0]};
    unh_dq = {operand_b[63:32], operand_a[63:32]};
  end

  // narrowing packs: operand_a fills the low half
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pk_sswb[8*i +: 8]      = sat_s16_s8(operand_a[16*i +: 16]);
      pk_sswb[32 + 8*i +: 8] = sat_s16_s8(operand_b[16*i +: 16]);
      pk_uswb[8*i +: 8]      = sat_s16_u8(operand_a[16*i +: 16]);
      pk_uswb[32 + 8*i +: 8] = sat_s16_u8(operand_b[16*i +: 16]);
    end
    for (int i = 0; i < 2; i++) begin
      pk_ssdw[16*i +: 16]      = sat_s32_s16(operand_a[32*i +: 32]);
      pk_ssdw[32 + 16*i +: 16] = sat_s32_s16(operand_b[32*i +: 32]);
    end
  end

  // shifts: logical zero past lane width, arithmetic clamps to width-1
  assign ok16 = (shift_count[31:4] == '0);
  assign ok32 = (shift_count[31:5] == '0);
  assign ok64 = (shift_count[31:6] == '0);
  assign na16 = ok16 ? shift_count[3:0] : 4'hf;
  assign na32 = ok32 ? shift_count[4:0] : 5'h1f;
  assign na64 = ok64 ? shift_count[5:0] : 6'h3f;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sll16[16*i +: 16] = ok16 ? (operand_a[16*i +: 16] << shift_count[3:0]) : 16'h0000;
      srl16[16*i +: 16] = ok16 ? (operand_a[16*i +: 16] >> shift_count[3:0]) : 16'h0000;
      sra16[16*i +: 16] = $signed(operand_a[16*i +: 16]) >>> na16;
    end
    for (int i = 0; i < 2; i++) begin
      sll32[32*i +: 32] = ok32 ? (operand_a[32*i +: 32] << shift_count[4:0]) : 32'h0;
      srl32[32*i +: 32] = ok32 ? (operand_a[32*i +: 32] >> shift_count[4:0]) : 32'h0;
      sra32[32*i +: 32] = $signed(operand_a[32*i +: 32]) >>> na32;
    end
    sll64 = ok64 ? (operand_a << shift_count[5:0]) : 64'h0;
    srl64 = ok64 ? (operand_a >> shift_count[5:0]) : 64'h0;
    sra64 = $signed(operand_a) >>> na64;
  end

  always_comb begin
    case (command) inside
      psimd_pkg::CMD_ADD_B, psimd_pkg::CMD_ADDS_B, psimd_pkg::CMD_ADDUS_B,
      psimd_pkg::CMD_SUB_B, psimd_pkg::CMD_SUBS_B, psimd_pkg::CMD_SUBUS_B,
      psimd_pkg::CMD_CMPEQ_B, psimd_pkg::CMD_CMPGT_B:
        result = r8;
      psimd_pkg::CMD_ADD_W, psimd_pkg::CMD_ADDS_W, psimd_pkg::CMD_ADDUS_W,
      psimd_pkg::CMD_SUB_W, psimd_pkg::CMD_SUBS_W, psimd_pkg::CMD_SUBUS_W,
      psimd_pkg::CMD_CMPEQ_W, psimd_pkg::CMD_CMPGT_W:
        result = r16;
      psimd_pkg::CMD_ADD_D, psimd_pkg::CMD_SUB_D,
      psimd_pkg::CMD_CMPEQ_D, psimd_pkg::CMD_CMPGT_D:
        result = r32;
      psimd_pkg::CMD_MULL_W:    result = mull;
      psimd_pkg::CMD_MULH_W:    result = mulh;
      psimd_pkg::CMD_MADD_WD:   result = madd;
      psimd_pkg::CMD_UNPCKL_BW: result = unl_bw;
      psimd_pkg::CMD_UNPCKL_WD: result = unl_wd;
      psimd_pkg::CMD_UNPCKL_DQ: result = unl_dq;
      psimd_pkg::CMD_UNPCKH_BW: result = unh_bw;
      psimd_pkg::CMD_UNPCKH_WD: result = unh_wd;
      psimd_pkg::CMD_UNPCKH_DQ: result = unh_dq;
      psimd_pkg::CMD_PACKSS_WB: result = pk_sswb;
      psimd_pkg::CMD_PACKSS_DW: result = pk_ssdw;
      psimd_pkg::CMD_PACKUS_WB: result = pk_uswb;
      psimd_pkg::CMD_SLL_W:     result = sll16;
      psimd_pkg::CMD_SLL_D:     result = sll32;
      psimd_pkg::CMD_SLL_Q:     result = sll64;
      psimd_pkg::CMD_SRL_W:     result = srl16;
      psimd_pkg::CMD_SRL_D:     result = srl32;
      psimd_pkg::CMD_SRL_Q:     result = srl64;
      psimd_pkg::CMD_SRA_W:     result = sra16;
      psimd_pkg::CMD_SRA_D:     result = sra32;
      psimd_pkg::CMD_SRA_Q:     result = sra64;
      default:                  result = '0;  // unused codes give zero
    endcase
  end

endmodule

@@ hdl/packed_integer_simd_alu.sv @@
// Flow: a request passes the input register, then the result register.
// Throughput: 1 request per cycle unless the result side stalls; the whole
//   op is one pass through psimd_exec, whose deepest path is a 16x16 word
//   multiply plus the madd pair add.
// Reset: synchronous, active high; clears both stage valid flags, payloads
//   are not reset. The block holds no other state.
// -----------------------------------------------------------------------------
// packed_integer_simd_alu
// 64-bit packed-integer SIMD ALU with stream request/result channels.
// -----------------------------------------------------------------------------
module packed_integer_simd_alu (
  input  logic                             clk,
  input  logic                             rst,
  // request channel
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // command[5:0], operand_a[69:6], operand_b[133:70], shift_count[165:134], pad
  input  logic [psimd_pkg::S_DATA_W-1:0]   s_tdata,
  // result channel
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // result[63:0]
  output logic [psimd_pkg::DATA_W-1:0]     m_tdata
);

  localparam int A_LO = psimd_pkg::CMD_W;
  localparam int B_LO = A_LO + psimd_pkg::DATA_W;
  localparam int C_LO = B_LO + psimd_pkg::DATA_W;

  // input stage
  logic                             stg_valid;
  psimd_pkg::cmd_t                  stg_command;
  logic [psimd_pkg::DATA_W-1:0]     stg_a;
  logic [psimd_pkg::DATA_W-1:0]     stg_b;
  logic [psimd_pkg::COUNT_W-1:0]    stg_count;

  logic [psimd_pkg::DATA_W-1:0]     result_next;
  logic                             out_load;

  // result register can take a new value when empty or being drained
  assign out_load = !m_tvalid || m_tready;
  // input stage accepts when empty or moving forward this cycle
  assign s_tready = !stg_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (s_tready) begin
        stg_valid <= s_tvalid;
      end
      if (out_load) begin
        m_tvalid <= stg_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stg_command <= s_tdata[A_LO-1:0];
      stg_a       <= s_tdata[B_LO-1:A_LO];
      stg_b       <= s_tdata[C_LO-1:B_LO];
      stg_count   <= s_tdata[C_LO+psimd_pkg::COUNT_W-1:C_LO];
    end
    if (out_load && stg_valid) begin
      m_tdata <= result_next;
    end
  end

  psimd_exec u_exec (
    .command     (stg_command),
    .operand_a   (stg_a),
    .operand_b   (stg_b),
    .shift_count (stg_count),
    .result      (result_next)
  );

  // a stalled input stage keeps its request
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stg_valid && !out_load |=> stg_valid && $stable(stg_command) && $stable(stg_a))
    else $error("input stage lost a stalled request");

  // an accepted request always lands in the input stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> stg_valid)
    else $error("accepted request not staged");

  // a staged request that moves on becomes a valid result
  a_stage_to_out: assert property (@(posedge clk) disable iff (rst)
    stg_valid && out_load |=> m_tvalid)
    else $error("staged request dropped");

  // with the result register empty the block is never back-pressured
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("ready low with empty output");

endmodule

@@ bench/psimd_result_checker.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// psimd_result_checker
// Watches both stream channels of the packed SIMD ALU, predicts each result
// from the accepted request and compares it in order.
// -----------------------------------------------------------------------------
module psimd_result_checker
  import psimd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [DATA_W-1:0]   m_tdata,
  output int                  mismatches,
  output int                  outstanding,
  output int                  results_checked
);

  typedef enum logic [1:0] {SH_LL, SH_LR, SH_AR} shift_kind_t;

  typedef struct {
    cmd_t              cmd;
    logic [63:0]       a;
    logic [63:0]       b;
    logic [31:0]       count;
    logic [63:0]       result;
  } alu_request_t;

  alu_request_t pending_results[$];
  int           error_total = 0;
  int           good_total  = 0;

  function automatic logic [63:0] lane_mask(int w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  // two's complement value of the low w bits, w up to 32
  function automatic longint to_signed(logic [63:0] v, int w);
    logic [63:0] m;
    m = lane_mask(w);
    v = v & m;
    if (v[w-1]) return longint'(v) - (longint'(1) << w);
    return longint'(v);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [63:0] lane_result(lop_t op, int w, logic [63:0] ua,
                                              logic [63:0] ub);
    logic [63:0] m;
    logic [63:0] t;
    longint      sa;
    longint      sb;
    longint      smax;
    longint      smin;
    m    = lane_mask(w);
    sa   = to_signed(ua, w);
    sb   = to_signed(ub, w);
    smax = longint'(m >> 1);
    smin = -smax - 1;
    case (op)
      LOP_ADD:   t = ua + ub;
      LOP_SUB:   t = ua - ub;
      LOP_ADDS:  t = clip(sa + sb, smin, smax);
      LOP_SUBS:  t = clip(sa - sb, smin, smax);
      LOP_ADDUS: t = (ua + ub > m) ? m : ua + ub;
      LOP_SUBUS: t = (ua > ub) ? ua - ub : 64'd0;
      LOP_CMPEQ: t = (ua == ub) ? m : 64'd0;
      LOP_CMPGT: t = (sa > sb) ? m : 64'd0;
      default:   t = '0;
    endcase
    return t & m;
  endfunction

  function automatic logic [63:0] lanewise(lop_t op, int w, logic [63:0] a,
                                           logic [63:0] b);
    logic [63:0] r;
    logic [63:0] m;
    r = '0;
    m = lane_mask(w);
    for (int i = 0; i < 64 / w; i++)
      r |= lane_result(op, w, (a >> (i * w)) & m, (b >> (i * w)) & m) << (i * w);
    return r;
  endfunction

  // signed word products, low or high half of each
  function automatic logic [63:0] word_multiply(bit high, logic [63:0] a,
                                                logic [63:0] b);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      t = to_signed(a >> (16 * i), 16) * to_signed(b >> (16 * i), 16);
      if (high) t = t >> 16;
      r |= (t & 64'hffff) << (16 * i);
    end
    return r;
  endfunction

  // pair sums wrap to 32 bits: two (-32768)^2 products give 0x80000000
  function automatic logic [63:0] word_pair_madd(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 0; i < 2; i++) begin
      t = to_signed(a >> (32 * i), 16) * to_signed(b >> (32 * i), 16)
        + to_signed(a >> (32 * i + 16), 16) * to_signed(b >> (32 * i + 16), 16);
      r |= (t & 64'hffff_ffff) << (32 * i);
    end
    return r;
  endfunction

  // a feeds the even lanes, b the odd ones
  function automatic logic [63:0] interleave(int w, bit high, logic [63:0] a,
                                             logic [63:0] b);
    logic [63:0] r;
    logic [63:0] m;
    int          n;
    int          base;
    r    = '0;
    m    = lane_mask(w);
    n    = 32 / w;
    base = high ? n : 0;
    for (int i = 0; i < n; i++) begin
      r |= ((a >> ((base + i) * w)) & m) << (2 * i * w);
      r |= ((b >> ((base + i) * w)) & m) << ((2 * i + 1) * w);
    end
    return r;
  endfunction

  // narrow 2w-bit lanes to w bits with saturation; a gives the low half
  function automatic logic [63:0] narrow(int w, bit uns, logic [63:0] a,
                                         logic [63:0] b);
    logic [63:0] r;
    logic [63:0] m;
    logic [63:0] t;
    longint      lo;
    longint      hi;
    int          sw;
    int          n;
    r  = '0;
    m  = lane_mask(w);
    sw = 2 * w;
    n  = 64 / sw;
    lo = uns ? 0 : -longint'(m >> 1) - 1;
    hi = uns ? longint'(m) : longint'(m >> 1);
    for (int i = 0; i < n; i++) begin
      t = clip(to_signed(a >> (i * sw), sw), lo, hi);
      r |= (t & m) << (i * w);
      t = clip(to_signed(b >> (i * sw), sw), lo, hi);
      r |= (t & m) << ((i + n) * w);
    end
    return r;
  endfunction

  // logical shifts past the lane give zero; arithmetic ones clamp the count
  function automatic logic [63:0] lane_shift(shift_kind_t kind, int w,
                                             logic [63:0] a, logic [31:0] count);
    logic [63:0] r;
    logic [63:0] m;
    logic [63:0] v;
    logic [63:0] x;
    int          n;
    r = '0;
    m = lane_mask(w);
    if (count > 32'(w - 1)) begin
      if (kind != SH_AR) return '0;
      count = 32'(w - 1);
    end
    n = int'(count);
    for (int i = 0; i < 64 / w; i++) begin
      v = (a >> (i * w)) & m;
      if (kind == SH_LL) begin
        x = (v << n) & m;
      end else begin
        x = v >> n;
        if (kind == SH_AR && v[w-1]) x |= m & ~(m >> n);
      end
      r |= x << (i * w);
    end
    return r;
  endfunction

  function automatic logic [63:0] packed_alu_result(cmd_t cmd, logic [63:0] a,
                                                    logic [63:0] b, logic [31:0] n);
    case (cmd)
      CMD_ADD_B:     return lanewise(LOP_ADD, 8, a, b);
      CMD_ADD_W:     return lanewise(LOP_ADD, 16, a, b);
      CMD_ADD_D:     return lanewise(LOP_ADD, 32, a, b);
      CMD_ADDS_B:    return lanewise(LOP_ADDS, 8, a, b);
      CMD_ADDS_W:    return lanewise(LOP_ADDS, 16, a, b);
      CMD_ADDUS_B:   return lanewise(LOP_ADDUS, 8, a, b);
      CMD_ADDUS_W:   return lanewise(LOP_ADDUS, 16, a, b);
      CMD_SUB_B:     return lanewise(LOP_SUB, 8, a, b);
      CMD_SUB_W:     return lanewise(LOP_SUB, 16, a, b);
      CMD_SUB_D:     return lanewise(LOP_SUB, 32, a, b);
      CMD_SUBS_B:    return lanewise(LOP_SUBS, 8, a, b);
      CMD_SUBS_W:    return lanewise(LOP_SUBS, 16, a, b);
      CMD_SUBUS_B:   return lanewise(LOP_SUBUS, 8, a, b);
      CMD_SUBUS_W:   return lanewise(LOP_SUBUS, 16, a, b);
      CMD_CMPEQ_B:   return lanewise(LOP_CMPEQ, 8, a, b);
      CMD_CMPEQ_W:   return lanewise(LOP_CMPEQ, 16, a, b);
      CMD_CMPEQ_D:   return lanewise(LOP_CMPEQ, 32, a, b);
      CMD_CMPGT_B:   return lanewise(LOP_CMPGT, 8, a, b);
      CMD_CMPGT_W:   return lanewise(LOP_CMPGT, 16, a, b);
      CMD_CMPGT_D:   return lanewise(LOP_CMPGT, 32, a, b);
      CMD_MULL_W:    return word_multiply(1'b0, a, b);
      CMD_MULH_W:    return word_multiply(1'b1, a, b);
      CMD_MADD_WD:   return word_pair_madd(a, b);
      CMD_UNPCKL_BW: return interleave(8, 1'b0, a, b);
      CMD_UNPCKL_WD: return interleave(16, 1'b0, a, b);
      CMD_UNPCKL_DQ: return interleave(32, 1'b0, a, b);
      CMD_UNPCKH_BW: return interleave(8, 1'b1, a, b);
      CMD_UNPCKH_WD: return interleave(16, 1'b1, a, b);
      CMD_UNPCKH_DQ: return interleave(32, 1'b1, a, b);
      CMD_PACKSS_WB: return narrow(8, 1'b0, a, b);
      CMD_PACKSS_DW: return narrow(16, 1'b0, a, b);
      CMD_PACKUS_WB: return narrow(8, 1'b1, a, b);
      CMD_SLL_W:     return lane_shift(SH_LL, 16, a, n);
      CMD_SLL_D:     return lane_shift(SH_LL, 32, a, n);
      CMD_SLL_Q:     return lane_shift(SH_LL, 64, a, n);
      CMD_SRL_W:     return lane_shift(SH_LR, 16, a, n);
      CMD_SRL_D:     return lane_shift(SH_LR, 32, a, n);
      CMD_SRL_Q:     return lane_shift(SH_LR, 64, a, n);
      CMD_SRA_W:     return lane_shift(SH_AR, 16, a, n);
      CMD_SRA_D:     return lane_shift(SH_AR, 32, a, n);
      CMD_SRA_Q:     return lane_shift(SH_AR, 64, a, n);
      default:       return '0;
    endcase
  endfunction

  // both channels are sampled at the clock edge, before the edge's updates land
  always @(posedge clk) begin
    alu_request_t req;
    alu_request_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          if (error_total < 10)
            $display("psimd_result_checker: result %h with no request pending", m_tdata);
          error_total++;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata !== want.result) begin
            if (error_total < 10)
              $display("psimd_result_checker: cmd %0d a %h b %h count %h: expected %h, got %h",
                       want.cmd, want.a, want.b, want.count, want.result, m_tdata);
            error_total++;
          end else begin
            good_total++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        req.cmd    = s_tdata[CMD_W-1:0];
        req.a      = s_tdata[CMD_W +: DATA_W];
        req.b      = s_tdata[CMD_W+DATA_W +: DATA_W];
        req.count  = s_tdata[CMD_W+2*DATA_W +: COUNT_W];
        req.result = packed_alu_result(req.cmd, req.a, req.b, req.count);
        pending_results.push_back(req);
      end
    end
    mismatches      <= error_total;
    outstanding     <= pending_results.size();
    results_checked <= good_total + error_total;
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Stream-level test of the packed SIMD ALU: a directed set of corner requests,
// then about a thousand random ones under bursty input and a stalling output.
// -----------------------------------------------------------------------------
module tb_top;
  import psimd_pkg::*;

  localparam int   RANDOM_REQUESTS = 1000;
  localparam int   WATCHDOG_LIMIT  = 2000;
  localparam int   DRAIN_CYCLES    = 6;   // two-stage pipe plus margin
  localparam cmd_t CMD_FIRST_UNUSED = 6'd41;
  localparam cmd_t CMD_LAST_UNUSED  = 6'd63;

  // receiver behavior, picked anew at random for each phase
  typedef enum logic [1:0] {RX_STREAM, RX_CHOPPY, RX_LONG_STALLS} rx_style_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;  // command, operand_a, operand_b, shift_count, pad
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [DATA_W-1:0]   m_tdata;        // result

  int        mismatches;
  int        outstanding;
  int        results_checked;
  int        requests_sent = 0;
  int        directed_sent = 0;
  logic [63:0] codes_seen  = '0;
  int        quiet_cycles  = 0;
  rx_style_t rx_style      = RX_STREAM;
  int        rx_phase      = 0;
  int        stall_left    = 0;

  always #6 clk = ~clk;

  packed_integer_simd_alu i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  psimd_result_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  // Result side: free-running, choppy, or long stalls, picked at random per phase.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_phase == 300) begin
        rx_phase <= 0;
        rx_style <= rx_style_t'($urandom_range(0, 2));
      end else begin
        rx_phase <= rx_phase + 1;
      end
      if (stall_left != 0) begin
        m_tready   <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        case (rx_style)
          RX_STREAM: m_tready <= 1'b1;
          RX_CHOPPY: begin
            if ($urandom_range(0, 2) == 0) begin
              m_tready   <= 1'b0;
              stall_left <= $urandom_range(0, 2);
            end else begin
              m_tready <= 1'b1;
            end
          end
          default: begin
            if ($urandom_range(0, 15) == 0) begin
              m_tready   <= 1'b0;
              stall_left <= $urandom_range(3, 12);
            end else begin
              m_tready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Watchdog: any accept on either side keeps it quiet.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: no handshake for %0d cycles, %0d results still due",
               WATCHDOG_LIMIT, outstanding);
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a rising edge; returns at the edge where the request is taken.
  // tvalid stays high across back-to-back requests.
  task automatic send_request(cmd_t cmd, logic [63:0] a, logic [63:0] b,
                              logic [31:0] count);
    logic [S_DATA_W-1:0] word;
    word = '0;
    word[CMD_W-1:0]                  = cmd;
    word[CMD_W +: DATA_W]            = a;
    word[CMD_W+DATA_W +: DATA_W]     = b;
    word[CMD_W+2*DATA_W +: COUNT_W]  = count;
    s_tdata  <= word;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
    codes_seen[cmd] = 1'b1;
  endtask

  task automatic pause_sender(int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Operands lean toward lane boundaries so saturation and sign cases show up.
  function automatic logic [63:0] pick_operand();
    logic [63:0] r;
    logic [15:0] word_edges[4] = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff};
    logic [7:0]  byte_edges[4] = '{8'h00, 8'h7f, 8'h80, 8'hff};
    r = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: for (int i = 0; i < 8; i++)
           if ($urandom_range(0, 1)) r[8*i +: 8] = byte_edges[$urandom_range(0, 3)];
      1: for (int i = 0; i < 4; i++)
           if ($urandom_range(0, 1)) r[16*i +: 16] = word_edges[$urandom_range(0, 3)];
      default: ;
    endcase
    return r;
  endfunction

  // Shifts mostly get counts near the lane widths, sometimes any 32-bit value.
  function automatic logic [31:0] pick_count(cmd_t cmd);
    if (cmd >= CMD_SLL_W && cmd <= CMD_SRA_Q && $urandom_range(0, 9) < 7)
      return $urandom_range(0, 66);
    return $urandom;
  endfunction

  initial begin
    cmd_t        cmd;
    logic [63:0] a;
    logic [63:0] b;
    int          burst_left;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    send_request(CMD_ADD_B, '1, 64'h0101_0101_0101_0101, 32'd0);         // byte wrap
    send_request(CMD_ADDS_B, 64'h7f80_7f80_7f80_7f80, 64'h01ff_0180_8080_7f7f, 32'd0);
    send_request(CMD_ADDUS_W, 64'hffff_8000_0001_0000, 64'h0001_8000_ffff_0000, 32'd0);
    send_request(CMD_SUBS_W, 64'h8000_7fff_8000_0000, 64'h0001_ffff_7fff_8000, 32'd0);
    send_request(CMD_SUBUS_B, 64'h0001_00ff_807f_0080, 64'h0100_ff00_7f80_ff01, 32'd0);
    send_request(CMD_CMPEQ_D, 64'h1234_5678_dead_beef, 64'h1234_5679_dead_beef, 32'd0);
    send_request(CMD_CMPGT_W, 64'h7fff_8000_0000_ffff, 64'h8000_7fff_ffff_0000, 32'd0);
    send_request(CMD_MULL_W, 64'h8000_8000_7fff_ffff, 64'h8000_7fff_8000_ffff, 32'd0);
    send_request(CMD_MULH_W, 64'h8000_8000_7fff_ffff, 64'h8000_7fff_8000_ffff, 32'd0);
    // both pairs at -32768 squared: doubleword wraps to 0x80000000
    send_request(CMD_MADD_WD, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, 32'd0);
    send_request(CMD_UNPCKL_BW, 64'h0706_0504_0302_0100, 64'hf7f6_f5f4_f3f2_f1f0, 32'd0);
    send_request(CMD_UNPCKH_DQ, 64'h0706_0504_0302_0100, 64'hf7f6_f5f4_f3f2_f1f0, 32'd0);
    send_request(CMD_PACKSS_WB, 64'h7fff_8000_0080_ff7f, 64'h0000_ffff_007f_ff80, 32'd0);
    send_request(CMD_PACKSS_DW, 64'h0001_0000_ffff_7fff, 64'h8000_0000_0000_7fff, 32'd0);
    send_request(CMD_PACKUS_WB, 64'h8000_00ff_0100_0001, 64'hffff_007f_7fff_0080, 32'd0);
    // shifts right at and past the lane edge
    send_request(CMD_SLL_W, 64'h8001_0001_ffff_1234, '0, 32'd15);
    send_request(CMD_SLL_W, 64'h8001_0001_ffff_1234, '1, 32'd16);
    send_request(CMD_SRL_Q, 64'h8000_0000_0000_0001, '0, 32'd63);
    send_request(CMD_SRL_Q, '1, '0, 32'd64);
    send_request(CMD_SRL_D, '1, '0, 32'hffff_ffff);
    send_request(CMD_SRA_W, 64'h8000_7fff_ffff_0001, '0, 32'd16);
    send_request(CMD_SRA_Q, 64'h8000_0000_0000_0000, '0, 32'hffff_ffff);
    send_request(CMD_SRA_D, 64'h8000_0001_7fff_ffff, '0, 32'd0);
    send_request(CMD_LAST_UNUSED, '1, '1, '1);                          // unused code
    send_request(CMD_ADD_D, '0, '0, '0);
    directed_sent = requests_sent;

    // random part: first 64 requests walk every code, then weighted picks
    burst_left = 0;
    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120)
                                                 : $urandom_range(1, 20);
      end
      burst_left--;
      if (k < 64)
        cmd = cmd_t'(k);
      else if ($urandom_range(0, 9) == 0)
        cmd = cmd_t'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
      else
        cmd = cmd_t'($urandom_range(CMD_ADD_B, CMD_SRA_Q));
      a = pick_operand();
      b = pick_operand();
      // give compares lanes that match
      if ($urandom_range(0, 3) == 0)
        for (int i = 0; i < 8; i++)
          if ($urandom_range(0, 1)) b[8*i +: 8] = a[8*i +: 8];
      send_request(cmd, a, b, pick_count(cmd));
    end
    s_tvalid <= 1'b0;

    // drain: wait for every expected result, then let the pipe settle
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d requests (%0d directed corners), %0d results checked",
             requests_sent, directed_sent, results_checked);
    $display("tb_top: %0d of 64 command codes, bursty input, three stall styles, %0d mismatches",
             $countones(codes_seen), mismatches);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ packed_integer_simd_alu.f @@
hdl/psimd_pkg.sv
hdl/psimd_lane.sv
hdl/psimd_exec.sv
hdl/packed_integer_simd_alu.sv
bench/psimd_result_checker.sv
bench/tb_top.sv
